// ===== rtl/core/im2c_pkg.sv =====
// Shared types, register codes and defaults for the im2col address generator.
`timescale 1ns / 1ps

package im2c_pkg;

	localparam int DEF_MAX_KERNEL = 8;
	localparam int DEF_ADDR_BITS  = 32;
	localparam int DEF_DIM_BITS   = 12;

	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_INDEX_BITS = 3;
	localparam int MUL_B_BITS     = 15;
	localparam int TAP_BITS       = 6;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IN_HEIGHT     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IN_WIDTH      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_HEIGHT = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_WIDTH  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_ROWS   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_COLS   = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_ROWS      = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_COLS      = 3'd7;

	typedef struct packed {
		logic [12:0] in_height;
		logic [12:0] in_width;
		logic [3:0]  kernel_height;
		logic [3:0]  kernel_width;
		logic [3:0]  stride_rows;
		logic [3:0]  stride_cols;
		logic [2:0]  pad_rows;
		logic [2:0]  pad_cols;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		in_height:     13'd1,
		in_width:      13'd1,
		kernel_height: 4'd1,
		kernel_width:  4'd1,
		stride_rows:   4'd1,
		stride_cols:   4'd1,
		pad_rows:      3'd0,
		pad_cols:      3'd0
	};

endpackage

// ===== rtl/core/im2c_cfg.sv =====
// Configuration register file for the im2col address generator.
`timescale 1ns / 1ps

module im2c_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [im2c_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [im2c_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output im2c_pkg::cfg_t                       cfg
);

	im2c_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= im2c_pkg::CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				im2c_pkg::REG_IN_HEIGHT:     cfg_q.in_height     <= cfg_data;
				im2c_pkg::REG_IN_WIDTH:      cfg_q.in_width      <= cfg_data;
				im2c_pkg::REG_KERNEL_HEIGHT: cfg_q.kernel_height <= cfg_data[3:0];
				im2c_pkg::REG_KERNEL_WIDTH:  cfg_q.kernel_width  <= cfg_data[3:0];
				im2c_pkg::REG_STRIDE_ROWS:   cfg_q.stride_rows   <= cfg_data[3:0];
				im2c_pkg::REG_STRIDE_COLS:   cfg_q.stride_cols   <= cfg_data[3:0];
				im2c_pkg::REG_PAD_ROWS:      cfg_q.pad_rows      <= cfg_data[2:0];
				im2c_pkg::REG_PAD_COLS:      cfg_q.pad_cols      <= cfg_data[2:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/im2c_alu.sv =====
// Shared multiply-add unit: y = a * b + c, signed product, wrapping sum.
`timescale 1ns / 1ps

module im2c_alu #(
	parameter int AW = 18,
	parameter int BW = im2c_pkg::MUL_B_BITS,
	parameter int SW = 33
) (
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	input  logic        [SW-1:0] c,
	output logic        [SW-1:0] y
);

	logic signed [AW+BW-1:0] prod;
	logic signed [SW-1:0]    prod_ext;

	assign prod     = a * b;
	// sign-extend the product before the wrapping add
	assign prod_ext = SW'(prod);
	assign y        = prod_ext + c;

endmodule

// ===== rtl/core/im2col_address_generator_unit.sv =====
// Top level of the im2col address generator: sequencer around the shared multiply-add.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid / in_stall  | plane_base, out_row, out_col
//  out     | output    | out_valid / out_stall| src_address, is_padding, tap_index, last_tap
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// A patch runs through setup steps on the multiply-add (row origin, column origin,
// row base address, tap address) and then gives one tap per cycle while the output
// is not stalled. A patch with a zero-sized kernel is accepted but gives no word.
// In the tap phase the same unit steps the address by 1 or by the row jump.
// Reset clears the sequencer, the output valid and the registers to defaults.
// out_stall holds the output word and freezes the tap walk; in_stall is high
// from acceptance until the last tap has been loaded into the output register.
`timescale 1ns / 1ps

module im2col_address_generator_unit #(
	parameter int MAX_KERNEL = im2c_pkg::DEF_MAX_KERNEL,
	parameter int ADDR_BITS  = im2c_pkg::DEF_ADDR_BITS,
	parameter int DIM_BITS   = im2c_pkg::DEF_DIM_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [im2c_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [im2c_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ADDR_BITS-1:0]                 plane_base,
	input  logic [DIM_BITS-1:0]                  out_row,
	input  logic [DIM_BITS-1:0]                  out_col,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ADDR_BITS-1:0]                 src_address,
	output logic                                 is_padding,
	output logic [im2c_pkg::TAP_BITS-1:0]        tap_index,
	output logic                                 last_tap
);

	localparam int BW = im2c_pkg::MUL_B_BITS;
	localparam int NW = DIM_BITS + 6;
	localparam int PW = NW + BW;
	localparam int SW = (ADDR_BITS > PW) ? ADDR_BITS : PW;
	localparam int CW = (NW > 13) ? NW : 13;
	localparam int KB = $clog2(MAX_KERNEL + 1);
	localparam int TB = im2c_pkg::TAP_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROW  = 3'd1;
	localparam logic [2:0] S_COL  = 3'd2;
	localparam logic [2:0] S_BASE = 3'd3;
	localparam logic [2:0] S_OFS  = 3'd4;
	localparam logic [2:0] S_TAP  = 3'd5;

	im2c_pkg::cfg_t cfg;

	logic [2:0]           state_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [DIM_BITS-1:0]  orow_q;
	logic [DIM_BITS-1:0]  ocol_q;
	logic [NW-1:0]        ih0_q;
	logic [NW-1:0]        iw0_q;
	logic [NW-1:0]        ih_q;
	logic [NW-1:0]        iw_q;
	logic [ADDR_BITS-1:0] cur_q;
	logic [KB-1:0]        kr_q;
	logic [KB-1:0]        kc_q;
	logic [TB-1:0]        tap_q;

	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] src_address_q;
	logic                 is_padding_q;
	logic [TB-1:0]        tap_index_q;
	logic                 last_tap_q;

	logic [KB-1:0]        kh_eff;
	logic [KB-1:0]        kw_eff;
	logic                 row_end;
	logic                 tap_last;
	logic                 in_plane;
	logic                 fire;
	logic                 in_accept;
	logic [BW-1:0]        row_jump;
	logic [CW-1:0]        ih_u;
	logic [CW-1:0]        iw_u;

	logic signed [NW-1:0] alu_a;
	logic signed [BW-1:0] alu_b;
	logic [SW-1:0]        alu_c;
	logic [SW-1:0]        alu_y;

	im2c_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	im2c_alu #(
		.AW (NW),
		.BW (BW),
		.SW (SW)
	) u_alu (
		.a (alu_a),
		.b (alu_b),
		.c (alu_c),
		.y (alu_y)
	);

	// saturate oversized kernels
	assign kh_eff = (cfg.kernel_height > 4'(MAX_KERNEL)) ? KB'(MAX_KERNEL)
	                                                     : KB'(cfg.kernel_height);
	assign kw_eff = (cfg.kernel_width > 4'(MAX_KERNEL)) ? KB'(MAX_KERNEL)
	                                                    : KB'(cfg.kernel_width);

	assign row_end  = (kc_q + KB'(1)) == kw_eff;
	assign tap_last = row_end && ((kr_q + KB'(1)) == kh_eff);

	// jump from the last tap of a kernel row to the first tap of the next
	assign row_jump = BW'(cfg.in_width) - BW'(kw_eff) + BW'(1);

	assign ih_u     = CW'(ih_q);
	assign iw_u     = CW'(iw_q);
	assign in_plane = !ih_q[NW-1] && !iw_q[NW-1]
	               && (ih_u < CW'(cfg.in_height)) && (iw_u < CW'(cfg.in_width));

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign fire      = (state_q == S_TAP) && (!out_valid_q || !out_stall);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_c = '0;
		unique case (state_q)
			S_ROW: begin
				alu_a = NW'(orow_q);
				alu_b = BW'(cfg.stride_rows);
				alu_c = SW'(0) - SW'(cfg.pad_rows);
			end
			S_COL: begin
				alu_a = NW'(ocol_q);
				alu_b = BW'(cfg.stride_cols);
				alu_c = SW'(0) - SW'(cfg.pad_cols);
			end
			S_BASE: begin
				alu_a = ih0_q;
				alu_b = BW'(cfg.in_width);
				alu_c = SW'(base_q);
			end
			S_OFS: begin
				alu_a = iw0_q;
				alu_b = BW'(1);
				alu_c = SW'(cur_q);
			end
			S_TAP: begin
				alu_a = NW'(1);
				alu_b = row_end ? row_jump : BW'(1);
				alu_c = SW'(cur_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
				alu_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load a word on every fired tap, drop it once taken
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// drop the patch at once when the kernel is empty
					if (in_accept && kh_eff != '0 && kw_eff != '0) begin
						state_q <= S_ROW;
					end
				end
				S_ROW:  state_q <= S_COL;
				S_COL:  state_q <= S_BASE;
				S_BASE: state_q <= S_OFS;
				S_OFS:  state_q <= S_TAP;
				S_TAP: begin
					if (fire && tap_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			base_q <= plane_base;
			orow_q <= out_row;
			ocol_q <= out_col;
		end
		unique case (state_q)
			S_IDLE: begin
				kr_q  <= '0;
				kc_q  <= '0;
				tap_q <= '0;
			end
			S_ROW: begin
				ih0_q <= alu_y[NW-1:0];
				ih_q  <= alu_y[NW-1:0];
			end
			S_COL: begin
				iw0_q <= alu_y[NW-1:0];
				iw_q  <= alu_y[NW-1:0];
			end
			S_BASE: cur_q <= alu_y[ADDR_BITS-1:0];
			S_OFS:  cur_q <= alu_y[ADDR_BITS-1:0];
			S_TAP: begin
				if (fire) begin
					src_address_q <= in_plane ? cur_q : '0;
					is_padding_q  <= !in_plane;
					tap_index_q   <= tap_q;
					last_tap_q    <= tap_last;
					cur_q         <= alu_y[ADDR_BITS-1:0];
					tap_q         <= tap_q + TB'(1);
					if (row_end) begin
						kc_q <= '0;
						kr_q <= kr_q + KB'(1);
						ih_q <= ih_q + NW'(1);
						iw_q <= iw0_q;
					end else begin
						kc_q <= kc_q + KB'(1);
						iw_q <= iw_q + NW'(1);
					end
				end
			end
			default: begin
				kr_q <= '0;
				kc_q <= '0;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign src_address = src_address_q;
	assign is_padding  = is_padding_q;
	assign tap_index   = tap_index_q;
	assign last_tap    = last_tap_q;

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_padding |-> src_address == '0)
		else $error("padding word carries a nonzero address");

	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_tap |=> out_valid)
		else $error("tap walk broke off before the last tap");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_tap |-> tap_index == TB'(kh_eff * kw_eff - 1))
		else $error("last tap carries the wrong tap index");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && kh_eff != '0 && kw_eff != '0 |=> in_stall ##4 (state_q == S_TAP))
		else $error("setup sequence did not reach the tap phase");

endmodule

// ===== tb/tb_im2col_address_generator_unit.sv =====
// Self-checking testbench for the im2col address generator: patch stimulus and tap scoreboard.
`timescale 1ns / 1ps

module tb_im2col_address_generator_unit;

	localparam int     CLK_PERIOD   = 8;
	localparam int     SETTLE       = 16;
	localparam int     LONG_HOLD    = 300;
	localparam int     RANDOM_WORDS = 200;
	localparam longint CYCLE_LIMIT  = 5000000;

	typedef struct packed {
		logic [31:0] src_address;
		logic        is_padding;
		logic [5:0]  tap_index;
		logic        last_tap;
	} tap_word_t;

	class tap_scoreboard;
		im2c_pkg::cfg_t shape;
		tap_word_t      taps_due[$];
		int             errors;

		function new();
			shape = im2c_pkg::CFG_RESET;
			errors = 0;
		endfunction

		function void set_reg(logic [im2c_pkg::CFG_INDEX_BITS-1:0] idx,
				logic [im2c_pkg::CFG_DATA_BITS-1:0] data);
			case (idx)
				im2c_pkg::REG_IN_HEIGHT:     shape.in_height = data;
				im2c_pkg::REG_IN_WIDTH:      shape.in_width = data;
				im2c_pkg::REG_KERNEL_HEIGHT: shape.kernel_height = data[3:0];
				im2c_pkg::REG_KERNEL_WIDTH:  shape.kernel_width = data[3:0];
				im2c_pkg::REG_STRIDE_ROWS:   shape.stride_rows = data[3:0];
				im2c_pkg::REG_STRIDE_COLS:   shape.stride_cols = data[3:0];
				im2c_pkg::REG_PAD_ROWS:      shape.pad_rows = data[2:0];
				im2c_pkg::REG_PAD_COLS:      shape.pad_cols = data[2:0];
				default: ;
			endcase
		endfunction

		// Expand one patch into its taps, kernel row outer, kernel column inner.
		function void note_patch(logic [31:0] base, logic [11:0] row, logic [11:0] col);
			int kh, kw, hgt, wid, row_i, col_i, sr, sc, pr, pc, ih, iw;
			tap_word_t w;
			kh = int'(shape.kernel_height);
			kw = int'(shape.kernel_width);
			if (kh > im2c_pkg::DEF_MAX_KERNEL) kh = im2c_pkg::DEF_MAX_KERNEL;
			if (kw > im2c_pkg::DEF_MAX_KERNEL) kw = im2c_pkg::DEF_MAX_KERNEL;
			hgt = int'(shape.in_height);
			wid = int'(shape.in_width);
			row_i = int'(row);
			col_i = int'(col);
			sr = int'(shape.stride_rows);
			sc = int'(shape.stride_cols);
			pr = int'(shape.pad_rows);
			pc = int'(shape.pad_cols);
			for (int kr = 0; kr < kh; kr++) begin
				ih = row_i * sr + kr - pr;
				for (int kc = 0; kc < kw; kc++) begin
					iw = col_i * sc + kc - pc;
					if (ih >= 0 && iw >= 0 && ih < hgt && iw < wid) begin
						w.src_address = base + 32'(ih * wid + iw);
						w.is_padding = 1'b0;
					end else begin
						w.src_address = '0;
						w.is_padding = 1'b1;
					end
					w.tap_index = 6'(kr * kw + kc);
					w.last_tap = (kr == kh - 1) && (kc == kw - 1);
					taps_due.push_back(w);
				end
			end
		endfunction

		function void check_tap(tap_word_t got);
			tap_word_t want;
			if (taps_due.size() == 0) begin
				$error("unexpected word: src_address=%h is_padding=%b tap_index=%0d last_tap=%b",
					got.src_address, got.is_padding, got.tap_index, got.last_tap);
				errors++;
			end else begin
				want = taps_due.pop_front();
				if (got.src_address !== want.src_address) begin
					$error("src_address: expected %h, got %h", want.src_address, got.src_address);
					errors++;
				end
				if (got.is_padding !== want.is_padding) begin
					$error("is_padding: expected %b, got %b", want.is_padding, got.is_padding);
					errors++;
				end
				if (got.tap_index !== want.tap_index) begin
					$error("tap_index: expected %0d, got %0d", want.tap_index, got.tap_index);
					errors++;
				end
				if (got.last_tap !== want.last_tap) begin
					$error("last_tap: expected %b, got %b", want.last_tap, got.last_tap);
					errors++;
				end
			end
		endfunction

		function int pending();
			return taps_due.size();
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_write;
	logic [im2c_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
	logic [im2c_pkg::CFG_DATA_BITS-1:0]   cfg_data;
	logic                                 in_valid;
	logic                                 in_stall;
	logic [31:0]                          plane_base;
	logic [11:0]                          out_row;
	logic [11:0]                          out_col;
	logic                                 out_valid;
	logic                                 out_stall;
	logic [31:0]                          src_address;
	logic                                 is_padding;
	logic [im2c_pkg::TAP_BITS-1:0]        tap_index;
	logic                                 last_tap;

	logic   hold_req;
	logic   sender_quiet;
	int     row_span;
	int     col_span;
	longint cycle_count = 0;

	tap_scoreboard sb = new();

	im2col_address_generator_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.plane_base (plane_base),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.src_address(src_address),
		.is_padding (is_padding),
		.tap_index  (tap_index),
		.last_tap   (last_tap)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_im2col_address_generator_unit failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_patch(plane_base, out_row, out_col);
			if (out_valid && !out_stall)
				sb.check_tap({src_address, is_padding, tap_index, last_tap});
		end
	end

	// Receiver: free runs, short and long stalls, and one long hold on request.
	initial begin
		int stall_left, run_left, pick;
		out_stall = 1'b0;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				out_stall <= 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					run_left = $urandom_range(5, 30);
					out_stall <= 1'b0;
				end else begin
					if (pick < 85) stall_left = $urandom_range(0, 2);
					else if (pick < 95) stall_left = $urandom_range(3, 9);
					else stall_left = $urandom_range(19, 59);
					out_stall <= 1'b1;
				end
			end
		end
	end

	task automatic write_reg(logic [im2c_pkg::CFG_INDEX_BITS-1:0] idx,
			logic [im2c_pkg::CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	// Drop valid, wait for every outstanding tap, then let a zero-kernel patch finish.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_shape(logic [12:0] h, logic [12:0] w, logic [3:0] kh, logic [3:0] kw,
			logic [3:0] sr, logic [3:0] sc, logic [2:0] pr, logic [2:0] pc);
		drain_results();
		write_reg(im2c_pkg::REG_IN_HEIGHT, h);
		write_reg(im2c_pkg::REG_IN_WIDTH, w);
		write_reg(im2c_pkg::REG_KERNEL_HEIGHT, 13'(kh));
		write_reg(im2c_pkg::REG_KERNEL_WIDTH, 13'(kw));
		write_reg(im2c_pkg::REG_STRIDE_ROWS, 13'(sr));
		write_reg(im2c_pkg::REG_STRIDE_COLS, 13'(sc));
		write_reg(im2c_pkg::REG_PAD_ROWS, 13'(pr));
		write_reg(im2c_pkg::REG_PAD_COLS, 13'(pc));
	endtask

	// Offer one patch word, hold it until taken, then idle for a random gap, which may be none.
	task automatic send_patch(logic [31:0] base, logic [11:0] row, logic [11:0] col);
		int gap, pick;
		@(negedge clk);
		in_valid <= 1'b1;
		plane_base <= base;
		out_row <= row;
		out_col <= col;
		do @(posedge clk); while (in_stall !== 1'b0);
		pick = $urandom_range(0, 99);
		if (sender_quiet || pick < 55) gap = 0;
		else if (pick < 85) gap = $urandom_range(1, 3);
		else if (pick < 95) gap = $urandom_range(4, 8);
		else gap = $urandom_range(15, 40);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic random_setup();
		int pick;
		logic [12:0] h, w;
		logic [3:0] kh, kw, sr, sc;
		logic [2:0] pr, pc;
		pick = $urandom_range(0, 9);
		h = 13'($urandom_range(1, 40));
		w = 13'($urandom_range(1, 40));
		kh = 4'($urandom_range(1, 5));
		kw = 4'($urandom_range(1, 5));
		sr = 4'($urandom_range(1, 3));
		sc = 4'($urandom_range(1, 3));
		pr = 3'($urandom_range(0, 7));
		pc = 3'($urandom_range(0, 7));
		case (pick)
			0: begin
				h = 13'($urandom_range(4000, 8191));
				w = 13'($urandom_range(4000, 8191));
			end
			1: begin
				h = 13'($urandom_range(0, 2));
				w = 13'($urandom_range(0, 2));
			end
			2: begin
				kh = 4'($urandom_range(6, 15));
				kw = 4'($urandom_range(6, 15));
			end
			3: begin
				sr = 4'($urandom_range(0, 15));
				sc = 4'($urandom_range(0, 15));
			end
			default: ;
		endcase
		set_shape(h, w, kh, kw, sr, sc, pr, pc);
		// keep most patches near the padded plane
		row_span = (int'(h) + 2 * int'(pr)) / ((sr == 4'd0) ? 1 : int'(sr)) + 1;
		col_span = (int'(w) + 2 * int'(pc)) / ((sc == 4'd0) ? 1 : int'(sc)) + 1;
		if (row_span > 4095) row_span = 4095;
		if (col_span > 4095) col_span = 4095;
	endtask

	initial begin
		int n, sent;
		logic [11:0] row, col;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		plane_base = '0;
		out_row = '0;
		out_col = '0;
		hold_req = 1'b0;
		sender_quiet = 1'b0;
		row_span = 1;
		col_span = 1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset shape: 1x1 plane, 1x1 kernel
		send_patch(32'hFFFF_FFFF, 12'd0, 12'd0);
		send_patch(32'h0000_0000, 12'd0, 12'd1);
		send_patch(32'h8000_0000, 12'd4095, 12'd0);

		// 3x3 with padding of one: corners, interior, address wrap
		set_shape(13'd5, 13'd6, 4'd3, 4'd3, 4'd1, 4'd1, 3'd1, 3'd1);
		send_patch(32'h0000_0000, 12'd0, 12'd0);
		send_patch(32'hFFFF_FFF0, 12'd4, 12'd5);
		send_patch($urandom, 12'd2, 12'd2);
		send_patch(32'h0000_1234, 12'd4095, 12'd4095);

		// largest legal kernel and padding, stride of 8
		set_shape(13'd4096, 13'd4096, 4'd8, 4'd8, 4'd8, 4'd8, 3'd7, 3'd7);
		send_patch(32'h0000_0000, 12'd0, 12'd0);
		send_patch(32'hFFFF_FFFF, 12'd511, 12'd511);

		// oversized kernel saturates, full-width registers
		set_shape(13'd8191, 13'd8191, 4'd15, 4'd15, 4'd15, 4'd15, 3'd0, 3'd0);
		send_patch(32'hAAAA_AAAA, 12'd100, 12'd100);
		send_patch(32'h5555_5555, 12'd4095, 12'd4095);

		// zero stride pins every patch to the same origin
		set_shape(13'd7, 13'd9, 4'd3, 4'd4, 4'd0, 4'd0, 3'd2, 3'd3);
		send_patch(32'h0000_0100, 12'd4095, 12'd4095);
		send_patch(32'h0000_0200, 12'd0, 12'd0);

		// empty plane: every tap is padding
		set_shape(13'd0, 13'd3, 4'd2, 4'd2, 4'd1, 4'd1, 3'd0, 3'd0);
		send_patch($urandom, 12'd1, 12'd0);
		set_shape(13'd3, 13'd0, 4'd2, 4'd2, 4'd1, 4'd1, 3'd0, 3'd0);
		send_patch($urandom, 12'd0, 12'd1);

		// empty kernel: patches give no taps
		set_shape(13'd16, 13'd16, 4'd0, 4'd3, 4'd1, 4'd1, 3'd1, 3'd1);
		send_patch($urandom, 12'd3, 12'd3);
		send_patch($urandom, 12'd4, 12'd4);
		set_shape(13'd16, 13'd16, 4'd3, 4'd0, 4'd1, 4'd1, 3'd1, 3'd1);
		send_patch($urandom, 12'd5, 12'd5);

		sent = 0;
		for (int phase = 0; sent < RANDOM_WORDS; phase++) begin
			random_setup();
			n = $urandom_range(12, 28);
			// back-pressure phase: sender keeps offering while the receiver holds off
			if (phase == 2) begin
				sender_quiet = 1'b1;
				hold_req = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				if (phase == 4 && i == n / 2)
					drain_results();
				row = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 4095)) :
					12'($urandom_range(0, row_span));
				col = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 4095)) :
					12'($urandom_range(0, col_span));
				send_patch($urandom, row, col);
				sent++;
			end
			sender_quiet = 1'b0;
		end

		drain_results();
		if (sb.errors == 0)
			$display("tb_im2col_address_generator_unit passed");
		else
			$display("tb_im2col_address_generator_unit failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/im2c_pkg.sv
rtl/core/im2c_cfg.sv
rtl/core/im2c_alu.sv
rtl/core/im2col_address_generator_unit.sv
tb/tb_im2col_address_generator_unit.sv
